// ===== rtl/core/wsd_pkg.sv =====
// Package for the WebSocket frame deframer.
// Holds parse phase, payload mode and event codes, opcodes and defaults.
// No dependencies; imported by every module under rtl/core.
package wsd_pkg;

  localparam int LengthBitsDefault = 64;
  localparam logic [31:0] MaxPayloadReset = 32'd1048576;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CLOSED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_DISCARD = 2'd0,
    MODE_DELIVER = 2'd1,
    MODE_PONG    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_MSG_BYTE   = 3'd0,
    EV_MSG_END    = 3'd1,
    EV_PONG_BYTE  = 3'd2,
    EV_PONG_EMPTY = 3'd3,
    EV_CLOSE      = 3'd4,
    EV_MASKED     = 3'd5,
    EV_OVERSIZE   = 3'd6
  } ev_kind_t;

  typedef struct packed {
    logic       valid;
    ev_kind_t   kind;
    logic [7:0] data;
    logic       last;
  } event_t;

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
// WebSocket frame deframer, top level. Instantiates wsd_in_stage, wsd_parser
// and wsd_out_stage; types and codes come from wsd_pkg.
//
// Takes a server-to-client WebSocket stream one byte per beat and gives at
// most one event beat per input byte. Each byte passes through an input
// register, combinational parse logic and a result register, so a byte is
// accepted every clock as long as the output side keeps taking beats, and
// its event (if any) is presented from the result register after the byte
// has passed the input register; a stalled output holds the result register
// and then the input register; once both hold a beat that cannot move on,
// in_ready drops. Masked headers give a masked event on their second byte
// and parsing restarts at the next byte. A close frame gives one event and
// all later input is taken and dropped until rst. Text and binary payloads
// come out up to the first zero byte, with frame_last on the final payload
// byte (an end event when that byte is not delivered). Frames longer than
// max_payload_len (written through cfg_we/cfg_data, reset 1 MiB) give an
// oversize event and are skipped; ping and close ignore the limit. The
// extended length is held in LENGTH_BITS bits and wraps modulo 2^LENGTH_BITS.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_payload_len
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // event channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [7:0]  data_byte,
  output logic        frame_last
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  event_t     ev;

  // Advance the held byte through the parser whenever the result register
  // is empty or being drained this cycle.
  assign advance = held_valid && can_load;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (advance),
    .in_byte  (held_byte),
    .ev       (ev)
  );

  wsd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ev         (ev),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .data_byte  (data_byte),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/core/wsd_in_stage.sv =====
// Input register of the WebSocket frame deframer.
// Holds one received byte until the parser takes it; uses wsd_pkg.
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready   = !valid_q || advance;
  assign held_valid = valid_q;
  assign held_byte  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/wsd_parser.sv =====
// Frame parser of the WebSocket frame deframer: parse state, length limit
// register and the per-byte event decision. Uses wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        advance,
  input  logic [7:0]  in_byte,
  output event_t      ev
);

  phase_t                   phase, phase_next;
  logic [3:0]               opcode, opcode_next;
  logic [LENGTH_BITS-1:0]   remaining, remaining_next;
  logic [3:0]               ext_left, ext_left_next;
  mode_t                    mode, mode_next;
  logic                     zero_seen, zero_seen_next;
  logic [31:0]              max_len;

  logic                   is_ext;
  logic [LENGTH_BITS-1:0] ext_shift;
  logic [3:0]             ext_left_dec;
  logic                   ext_done;
  logic [LENGTH_BITS-1:0] frame_len;
  logic                   len_zero;
  logic                   oversize;
  logic                   len_complete;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   pay_last;
  logic                   deliver_byte;

  assign is_ext       = (in_byte[6:0] == LEN_CODE_16) || (in_byte[6:0] == LEN_CODE_64);
  assign ext_shift    = {remaining[LENGTH_BITS-9:0], in_byte};
  assign ext_left_dec = ext_left - 4'(ext_left != 4'd0);
  assign ext_done     = (ext_left_dec == 4'd0);
  assign frame_len    = (phase == PH_HDR1) ?
                        {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]} : ext_shift;
  assign len_zero     = (frame_len == '0);
  assign oversize     = {32'd0, frame_len} > {{LENGTH_BITS{1'b0}}, max_len};
  assign len_complete = ((phase == PH_HDR1) && !in_byte[7] && !is_ext) ||
                        ((phase == PH_EXT) && ext_done);
  assign rem_dec      = remaining - LENGTH_BITS'(remaining != '0);
  assign pay_last     = (rem_dec == '0);
  assign deliver_byte = !zero_seen && (in_byte != 8'd0);

  // Next state
  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    remaining_next = remaining;
    ext_left_next  = ext_left;
    mode_next      = mode;
    zero_seen_next = zero_seen;
    unique case (phase)
      PH_HDR0: begin
        opcode_next = in_byte[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        if (in_byte[7]) begin
          phase_next = PH_HDR0;
        end else if (is_ext) begin
          remaining_next = '0;
          ext_left_next  = (in_byte[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          phase_next     = PH_EXT;
        end
      end
      PH_EXT: begin
        remaining_next = ext_shift;
        ext_left_next  = ext_left_dec;
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        if (pay_last) begin
          phase_next = PH_HDR0;
        end
        if (mode == MODE_DELIVER && !deliver_byte) begin
          zero_seen_next = 1'b1;
        end
      end
      PH_CLOSED: begin
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (len_complete) begin
      remaining_next = frame_len;
      if (opcode == OP_PING) begin
        if (len_zero) begin
          phase_next = PH_HDR0;
        end else begin
          mode_next  = MODE_PONG;
          phase_next = PH_PAYLOAD;
        end
      end else if (opcode == OP_CLOSE) begin
        phase_next = PH_CLOSED;
        mode_next  = MODE_DISCARD;
      end else if (len_zero) begin
        phase_next = PH_HDR0;
      end else begin
        phase_next     = PH_PAYLOAD;
        zero_seen_next = 1'b0;
        if (!oversize && (opcode == OP_TEXT || opcode == OP_BINARY)) begin
          mode_next = MODE_DELIVER;
        end else begin
          mode_next = MODE_DISCARD;
        end
      end
    end
  end

  // Event for the current byte
  always_comb begin
    ev = '{valid: 1'b0, kind: EV_MSG_BYTE, data: 8'd0, last: 1'b0};
    unique case (phase)
      PH_HDR1: begin
        if (in_byte[7]) begin
          ev.valid = 1'b1;
          ev.kind  = EV_MASKED;
        end
      end
      PH_PAYLOAD: begin
        if (mode == MODE_PONG) begin
          ev = '{valid: 1'b1, kind: EV_PONG_BYTE, data: in_byte, last: pay_last};
        end else if (mode == MODE_DELIVER) begin
          if (deliver_byte) begin
            ev = '{valid: 1'b1, kind: EV_MSG_BYTE, data: in_byte, last: pay_last};
          end else if (pay_last) begin
            ev = '{valid: 1'b1, kind: EV_MSG_END, data: 8'd0, last: 1'b1};
          end
        end
      end
      default: begin
      end
    endcase

    if (len_complete) begin
      if (opcode == OP_PING) begin
        if (len_zero) begin
          ev.valid = 1'b1;
          ev.kind  = EV_PONG_EMPTY;
        end
      end else if (opcode == OP_CLOSE) begin
        ev.valid = 1'b1;
        ev.kind  = EV_CLOSE;
      end else if (!len_zero && oversize) begin
        ev.valid = 1'b1;
        ev.kind  = EV_OVERSIZE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      opcode    <= 4'd0;
      remaining <= '0;
      ext_left  <= 4'd0;
      mode      <= MODE_DISCARD;
      zero_seen <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      opcode    <= opcode_next;
      remaining <= remaining_next;
      ext_left  <= ext_left_next;
      mode      <= mode_next;
      zero_seen <= zero_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MaxPayloadReset;
    end else if (cfg_we) begin
      max_len <= cfg_data;
    end
  end

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// Result register of the WebSocket frame deframer.
// Holds one event until the consumer takes it; uses wsd_pkg.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  event_t     ev,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] data_byte,
  output logic       frame_last
);

  logic       valid_q;
  ev_kind_t   kind_q;
  logic [7:0] data_q;
  logic       last_q;

  assign can_load   = !valid_q || out_ready;
  assign out_valid  = valid_q;
  assign event_kind = kind_q;
  assign data_byte  = data_q;
  assign frame_last = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= ev.valid;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev.valid) begin
      kind_q <= ev.kind;
      data_q <= ev.data;
      last_q <= ev.last;
    end
  end

endmodule

// ===== test/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for websocket_frame_deframer: a directed stimulus table,
// then random frame streams under several payload limits, then a close frame.
// Depends on wsd_pkg and the deframer RTL; no other files.
module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int LEN_BITS = LengthBitsDefault;
  localparam logic [63:0] LEN_MASK =
      (LEN_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEN_BITS) - 64'd1);
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_SHOWN    = 10;
  localparam int GAP_PCT      = 6;

  typedef struct {
    ev_kind_t   kind;
    logic [7:0] data;
    logic       last;
  } ws_event_t;

  // One row of the directed table: a byte and, where typed in, its event.
  typedef struct {
    logic [7:0] b;
    bit         typed;
    bit         has;
    ws_event_t  ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic        frame_last;

  websocket_frame_deframer DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .data_byte  (data_byte),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the parser and its payload limit.
  phase_t      p_phase;
  logic [3:0]  p_opcode;
  logic [63:0] p_remaining;
  logic [3:0]  p_ext_left;
  mode_t       p_mode;
  bit          p_zero_hit;
  logic [31:0] p_max_len;

  ws_event_t   pending_events[$];
  stim_row_t   stim_rows[$];
  logic [7:0]  frame_bytes[$];
  ws_event_t   no_event;

  int  close_at;
  int  bytes_sent = 0;
  int  live_bytes = 0;
  int  events_seen = 0;
  int  limits_used = 0;
  int  fails = 0;
  int  cycles = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  function automatic ws_event_t make_event(ev_kind_t k, logic [7:0] d, logic l);
    ws_event_t ev;
    ev.kind = k;
    ev.data = d;
    ev.last = l;
    return ev;
  endfunction

  task automatic reset_deframer_model();
    p_phase     = PH_HDR0;
    p_opcode    = 4'h0;
    p_remaining = 64'd0;
    p_ext_left  = 4'd0;
    p_mode      = MODE_DISCARD;
    p_zero_hit  = 1'b0;
    p_max_len   = MaxPayloadReset;
  endtask

  // Length is complete: pick what the frame does with its payload.
  function automatic bit length_complete(output ws_event_t ev);
    logic [63:0] len;
    len = p_remaining & LEN_MASK;
    p_remaining = len;
    ev = make_event(EV_MSG_BYTE, 8'h00, 1'b0);
    if (p_opcode == OP_PING) begin
      if (len == 64'd0) begin
        p_phase = PH_HDR0;
        ev = make_event(EV_PONG_EMPTY, 8'h00, 1'b0);
        return 1'b1;
      end
      p_mode = MODE_PONG;
      p_phase = PH_PAYLOAD;
      return 1'b0;
    end
    if (p_opcode == OP_CLOSE) begin
      p_phase = PH_CLOSED;
      p_mode = MODE_DISCARD;
      ev = make_event(EV_CLOSE, 8'h00, 1'b0);
      return 1'b1;
    end
    if (len == 64'd0) begin
      p_phase = PH_HDR0;
      return 1'b0;
    end
    p_phase = PH_PAYLOAD;
    p_zero_hit = 1'b0;
    if (len > {32'd0, p_max_len}) begin
      p_mode = MODE_DISCARD;
      ev = make_event(EV_OVERSIZE, 8'h00, 1'b0);
      return 1'b1;
    end
    p_mode = (p_opcode == OP_TEXT || p_opcode == OP_BINARY) ? MODE_DELIVER : MODE_DISCARD;
    return 1'b0;
  endfunction

  // Advance the predictor by one byte; return 1 when the byte gives an event.
  function automatic bit deframe_byte(input logic [7:0] b, output ws_event_t ev);
    logic [6:0] len7;
    bit         last;
    ev = make_event(EV_MSG_BYTE, 8'h00, 1'b0);
    case (p_phase)
      PH_HDR0: begin
        p_opcode = b[3:0];
        p_phase = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        if (b[7]) begin
          p_phase = PH_HDR0;
          ev = make_event(EV_MASKED, 8'h00, 1'b0);
          return 1'b1;
        end
        len7 = b[6:0];
        p_remaining = 64'd0;
        if (len7 == LEN_CODE_16 || len7 == LEN_CODE_64) begin
          p_ext_left = (len7 == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          p_phase = PH_EXT;
          return 1'b0;
        end
        p_remaining = {57'd0, len7};
        return length_complete(ev);
      end
      PH_EXT: begin
        p_remaining = ((p_remaining << 8) | {56'd0, b}) & LEN_MASK;
        if (p_ext_left != 4'd0) p_ext_left = p_ext_left - 4'd1;
        if (p_ext_left != 4'd0) return 1'b0;
        return length_complete(ev);
      end
      PH_PAYLOAD: begin
        if (p_remaining != 64'd0) p_remaining = p_remaining - 64'd1;
        last = (p_remaining == 64'd0);
        if (last) p_phase = PH_HDR0;
        if (p_mode == MODE_PONG) begin
          ev = make_event(EV_PONG_BYTE, b, last);
          return 1'b1;
        end
        if (p_mode == MODE_DELIVER) begin
          if (!p_zero_hit && b != 8'h00) begin
            ev = make_event(EV_MSG_BYTE, b, last);
            return 1'b1;
          end
          p_zero_hit = 1'b1;
          if (last) begin
            ev = make_event(EV_MSG_END, 8'h00, 1'b1);
            return 1'b1;
          end
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Keep random bytes from closing the stream or starting a frame so long
  // that it swallows the rest of the run: turn close opcodes into ping and
  // cap extended lengths below 512.
  function automatic logic [7:0] tame_byte(input logic [7:0] b);
    case (p_phase)
      PH_HDR0: if (b[3:0] == OP_CLOSE) return b ^ 8'h01;
      PH_EXT: begin
        if (p_ext_left > 4'd2) return 8'h00;
        if (p_ext_left == 4'd2) return b & 8'h01;
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic add_row(input logic [7:0] b, input bit typed, input bit has,
                         input ws_event_t ev);
    stim_row_t r;
    r.b = b;
    r.typed = typed;
    r.has = has;
    r.ev = ev;
    stim_rows.push_back(r);
  endtask

  task automatic pred_row(input logic [7:0] b);
    add_row(b, 1'b0, 1'b0, no_event);
  endtask

  task automatic quiet_row(input logic [7:0] b);
    add_row(b, 1'b1, 1'b0, no_event);
  endtask

  task automatic want_row(input logic [7:0] b, input ev_kind_t k, input logic [7:0] d,
                          input logic l);
    add_row(b, 1'b1, 1'b1, make_event(k, d, l));
  endtask

  task automatic build_table();
    // Text with a zero in the middle: byte, nothing, then an end mark.
    quiet_row(8'h81); quiet_row(8'h03);
    want_row(8'h41, EV_MSG_BYTE, 8'h41, 1'b0);
    quiet_row(8'h00);
    want_row(8'hFF, EV_MSG_END, 8'h00, 1'b1);
    // Binary, extreme byte values delivered, last one marked.
    quiet_row(8'h82); quiet_row(8'h02);
    want_row(8'h01, EV_MSG_BYTE, 8'h01, 1'b0);
    want_row(8'hFF, EV_MSG_BYTE, 8'hFF, 1'b1);
    // Empty ping.
    quiet_row(8'h89);
    want_row(8'h00, EV_PONG_EMPTY, 8'h00, 1'b0);
    // Ping without FIN, 16-bit length of two: two pong bytes.
    pred_row(8'h09); pred_row(8'h7E); pred_row(8'h00); pred_row(8'h02);
    pred_row(8'h00); pred_row(8'h80);
    // Masked close header: flagged on its second byte, not a close.
    quiet_row(8'h88);
    want_row(8'hFF, EV_MASKED, 8'h00, 1'b0);
    // Empty text frame.
    pred_row(8'h81); pred_row(8'h00);
    // Continuation with reserved bits set: skipped.
    pred_row(8'h70); pred_row(8'h01); pred_row(8'hAA);
    // Binary with a non-minimal 64-bit length of one, final byte zero.
    pred_row(8'h02); pred_row(8'h7F);
    repeat (7) pred_row(8'h00);
    pred_row(8'h01); pred_row(8'h00);
    close_at = stim_rows.size();
    // Close with a 16-bit length of three; all later bytes are dropped.
    quiet_row(8'h88); quiet_row(8'h7E); quiet_row(8'h00);
    want_row(8'h03, EV_CLOSE, 8'h00, 1'b0);
    quiet_row(8'h41); quiet_row(8'h00); quiet_row(8'hFF);
    quiet_row(8'h81); quiet_row(8'h01); quiet_row(8'h41);
    quiet_row(8'h89); quiet_row(8'h00);
  endtask

  // Offer one byte: maybe idle first, then hold valid until the beat is taken.
  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_byte(input logic [7:0] raw, input bit shape, input bit typed,
                           input bit has, input ws_event_t typed_ev);
    logic [7:0] b;
    ws_event_t  ev;
    bit         got;
    b = shape ? tame_byte(raw) : raw;
    while (!steady && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (p_phase != PH_PAYLOAD || p_mode != MODE_DISCARD) live_bytes++;
    got = deframe_byte(b, ev);
    if (typed) begin
      if (has) pending_events.push_back(typed_ev);
    end else if (got) begin
      pending_events.push_back(ev);
    end
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected event is out and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    p_max_len = value;
    limits_used++;
  endtask

  task automatic put_header(input logic [3:0] op, input int len);
    int form;
    form = $urandom_range(99);
    frame_bytes.push_back({4'($urandom_range(15)), op});
    if (len > 125 || form < 12) begin
      frame_bytes.push_back({1'b0, LEN_CODE_16});
      frame_bytes.push_back(8'(len >> 8));
      frame_bytes.push_back(8'(len));
    end else if (form < 20) begin
      frame_bytes.push_back({1'b0, LEN_CODE_64});
      repeat (6) frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'(len >> 8));
      frame_bytes.push_back(8'(len));
    end else begin
      frame_bytes.push_back({1'b0, 7'(len)});
    end
  endtask

  task automatic put_payload(input int len, input int zero_pct);
    repeat (len) begin
      if ($urandom_range(99) < zero_pct) frame_bytes.push_back(8'h00);
      else frame_bytes.push_back(8'($urandom_range(255, 1)));
    end
  endtask

  function automatic int data_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 15) return $urandom_range(300, 126);
    return $urandom_range(20, 1);
  endfunction

  // Build one random frame; most are well formed, the rest masked, skipped,
  // cut short or plain noise.
  task automatic build_frame();
    int         pick;
    int         len;
    int         cut;
    logic [3:0] op;
    frame_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 50) begin
      op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      len = data_len();
      put_header(op, len);
      put_payload(len, 8);
    end else if (pick < 60) begin
      // Oversize when the limit is small enough to step over cheaply.
      do op = 4'($urandom_range(15)); while (op == OP_CLOSE || op == OP_PING);
      if (p_max_len < 32'd64) len = int'(p_max_len) + 1 + $urandom_range(8);
      else len = $urandom_range(20, 1);
      put_header(op, len);
      put_payload(len, 20);
    end else if (pick < 72) begin
      len = ($urandom_range(4) == 0) ? 0 : $urandom_range(16, 1);
      put_header(OP_PING, len);
      put_payload(len, 10);
    end else if (pick < 80) begin
      frame_bytes.push_back(8'($urandom_range(255)));
      frame_bytes.push_back({1'b1, 7'($urandom_range(127))});
    end else if (pick < 90) begin
      do op = 4'($urandom_range(15));
      while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE || op == OP_PING);
      len = $urandom_range(10);
      put_header(op, len);
      put_payload(len, 20);
    end else if (pick < 95) begin
      op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      len = $urandom_range(12, 2);
      put_header(op, len);
      put_payload(len, 8);
      cut = $urandom_range(3, 1);
      repeat (cut) void'(frame_bytes.pop_back());
    end else begin
      repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // Send whole random frames until about target more bytes have gone in.
  task automatic run_random(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b1, 1'b0, 1'b0, no_event);
    end
  endtask

  // Receiver: take events with random stalls, or hold off for one long
  // stretch when asked so the pipe fills and in_ready drops.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  // Compare every event beat with the oldest expected event.
  always @(posedge clk) begin : check_events
    ws_event_t want;
    if (!rst && out_valid && out_ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        if (fails < MAX_SHOWN)
          $display("tb: unexpected event kind=%0d data=%02h last=%0d",
                   event_kind, data_byte, frame_last);
        fails++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== 3'(want.kind) || data_byte !== want.data ||
            frame_last !== want.last) begin
          if (fails < MAX_SHOWN)
            $display("tb: event %0d: want kind/data/last %0d/%02h/%0d, got %0d/%02h/%0d",
                     events_seen, want.kind, want.data, want.last,
                     event_kind, data_byte, frame_last);
          fails++;
        end
      end
    end
  end

  // Bound the run so a hang ends it.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    no_event = make_event(EV_MSG_BYTE, 8'h00, 1'b0);
    reset_deframer_model();
    build_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table under the reset payload limit.
    for (int i = 0; i < close_at; i++)
      send_byte(stim_rows[i].b, 1'b0, stim_rows[i].typed, stim_rows[i].has, stim_rows[i].ev);

    // Zero limit: every nonempty data frame is oversize.
    write_limit(32'd0);
    run_random(90);
    // Widest limit, with both sides running flat out.
    write_limit(32'hFFFF_FFFF);
    steady = 1'b1;
    run_random(120);
    steady = 0;
    // Small limit; stall the receiver long enough to back up the input.
    write_limit(32'd8);
    hold_req = 1'b1;
    run_random(110);
    // Random small limit, with a full drain in the middle.
    write_limit(32'($urandom_range(40, 1)));
    run_random(50);
    settle();
    run_random(50);
    // Back to the reset limit.
    write_limit(MaxPayloadReset);
    run_random(110);

    // Finish any frame in progress, then close; everything after is dropped.
    while (p_phase != PH_HDR0)
      send_byte(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, no_event);
    for (int i = close_at; i < stim_rows.size(); i++)
      send_byte(stim_rows[i].b, 1'b0, stim_rows[i].typed, stim_rows[i].has, stim_rows[i].ev);
    settle();

    $display("tb: %0d bytes sent (%0d parsed), %0d events checked, %0d limit settings",
             bytes_sent, live_bytes, events_seen, limits_used);
    $display("tb: text, binary, ping, masked, oversize, skipped opcodes and close exercised");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fails);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
